[rtl/fpba_pkg.sv]
package fpba_pkg;

  // Input transaction kinds (carried on s_tuser)
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Fit policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_FIT_POLICY    = 1'b0;
  localparam logic CFG_BLOCKS_IN_USE = 1'b1;

  // Fixed field widths
  localparam int INDEX_W  = 4;
  localparam int AMOUNT_W = 16;
  localparam int TOTAL_W  = 20;
  localparam int USED_W   = 5;

  // Saturation limit of the reported free total
  localparam logic [TOTAL_W-1:0] SUM_MAX = 20'hFFFFF;

  // Control from the sequencer to the scan unit
  typedef struct packed {
    logic       clear;
    logic       alloc;
    logic [1:0] policy;
  } scan_ctrl_t;

endpackage

[rtl/fit_policy_block_allocator_core.sv]
// Block allocator with a table of free capacity per memory block. A load
// transaction (s_tuser 0) sets one block's capacity; an allocate transaction
// (s_tuser 1) places a request by first, best, worst or next fit, as the
// fit_policy register selects, and reduces the chosen block. Each input
// transaction returns one result with the grant flag, the block and the
// saturated free total over the blocks in use. The table sits in a single
// RAM read one entry per cycle by one shared compare-and-add unit. A load
// first writes its entry (ST_WRITE); every transaction then scans n entries
// (ST_SCAN), n being the clamped blocks_in_use, registers the result
// (ST_FINISH) and presents it (ST_DONE). s_tready is low from acceptance
// until the result is presented, so no new transaction is taken before. A
// result still stalled on m_tready when the next one is ready adds its wait.
// Entries never loaded read as zero from reset, with no clearing pass.
module fit_policy_block_allocator_core
  import fpba_pkg::*;
#(
  parameter int BLOCK_COUNT = 16,
  parameter int SIZE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [3:0] block_index, [19:4] amount
  input  logic        s_tuser,   // opcode
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] chosen_block, [23:4] free_total
  output logic        m_tuser,   // granted
  // Configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int IDXW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int CW   = IDXW + 1;
  localparam int SW   = SIZE_BITS + IDXW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [1:0]        fit_policy;
  logic [USED_W-1:0] blocks_in_use;

  // Transaction registers
  logic                 op;
  logic [INDEX_W-1:0]   idx;
  logic [SIZE_BITS-1:0] amt;
  logic                 load_ok;
  logic [CW-1:0]        n_blocks;
  logic [IDXW-1:0]      scan_start;

  // Scan control
  logic [IDXW-1:0] scan_addr;
  logic [CW-1:0]   issue_cnt;
  logic            rd_en;
  logic            rd_vld;
  logic            rd_ok;
  logic [IDXW-1:0] rd_idx;
  logic [BLOCK_COUNT-1:0] vbits;

  // Result holding
  logic               res_granted;
  logic [INDEX_W-1:0] res_chosen;
  logic [TOTAL_W-1:0] res_total;

  // Derived values
  logic [CW-1:0]        n_now;
  logic [IDXW-1:0]      start_sel;
  logic [31:0]          amt_in;
  logic [31:0]          idx_wide;
  logic [31:0]          pick_wide;
  logic [63:0]          total_wide;
  logic                 wr_en;
  logic [IDXW-1:0]      wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [SIZE_BITS-1:0] ram_rd;
  logic [SIZE_BITS-1:0] entry;
  scan_ctrl_t           ctrl;
  logic                 found;
  logic [IDXW-1:0]      pick_idx;
  logic [SIZE_BITS-1:0] pick_val;
  logic [SW-1:0]        sum;

  assign s_tready = (state == ST_IDLE);

  // Clamp the number of blocks in use to the table
  always_comb begin
    if (blocks_in_use == '0) begin
      n_now = CW'(1);
    end else if (32'(blocks_in_use) > BLOCK_COUNT) begin
      n_now = CW'(BLOCK_COUNT);
    end else begin
      n_now = CW'(blocks_in_use);
    end
    start_sel = (CW'(scan_start) < n_now) ? scan_start : '0;
    amt_in    = {16'b0, s_tdata[19:4]};
    idx_wide  = 32'(idx);
    pick_wide = 32'(pick_idx);
  end

  // Single RAM write port: load entry or shrink the picked block
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_wide[IDXW-1:0];
    wr_data = amt;
    if (state == ST_WRITE) begin
      wr_en = load_ok;
    end else if (state == ST_FINISH && op == OP_ALLOC && found) begin
      wr_en   = 1'b1;
      wr_addr = pick_idx;
      wr_data = pick_val - amt;
    end
  end

  assign rd_en = (state == ST_SCAN) && (issue_cnt < n_blocks);
  assign entry = ram_rd & {SIZE_BITS{rd_ok}};

  always_comb begin
    ctrl.clear  = s_tvalid && s_tready;
    ctrl.alloc  = (op == OP_ALLOC);
    ctrl.policy = fit_policy;
  end

  // Free total after the item, before saturation
  always_comb begin
    if (op == OP_ALLOC && found) begin
      total_wide = 64'(sum) - 64'(amt);
    end else begin
      total_wide = 64'(sum);
    end
  end

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (BLOCK_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_addr),
    .rd_data (ram_rd)
  );

  fpba_scan #(
    .SIZE_BITS (SIZE_BITS),
    .IDXW      (IDXW)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .data_vld (rd_vld),
    .data_idx (rd_idx),
    .data     (entry),
    .amt      (amt),
    .found    (found),
    .pick_idx (pick_idx),
    .pick_val (pick_val),
    .sum      (sum)
  );

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fit_policy    <= POL_FIRST;
      blocks_in_use <= 5'd16;
      scan_start    <= '0;
      vbits         <= '0;
      rd_vld        <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIT_POLICY:    fit_policy    <= cfg_data[1:0];
          CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data;
          default: ;
        endcase
      end

      // Read pipeline tags
      rd_vld <= rd_en;
      if (rd_en) begin
        rd_idx <= scan_addr;
        rd_ok  <= vbits[scan_addr];
      end

      if (wr_en) begin
        vbits[wr_addr] <= 1'b1;
      end

      // Drop the result once taken, unless a new one replaces it
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op        <= s_tuser;
            idx       <= s_tdata[3:0];
            amt       <= amt_in[SIZE_BITS-1:0];
            load_ok   <= (32'(s_tdata[3:0]) < BLOCK_COUNT);
            n_blocks  <= n_now;
            issue_cnt <= '0;
            if (s_tuser == OP_ALLOC && fit_policy == POL_NEXT) begin
              scan_addr <= start_sel;
            end else begin
              scan_addr <= '0;
            end
            state <= (s_tuser == OP_LOAD) ? ST_WRITE : ST_SCAN;
          end
        end
        ST_WRITE: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + CW'(1);
            if (CW'(scan_addr) + CW'(1) == n_blocks) begin
              scan_addr <= '0;
            end else begin
              scan_addr <= scan_addr + IDXW'(1);
            end
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (op == OP_ALLOC) begin
            res_granted <= found;
            res_chosen  <= found ? pick_wide[INDEX_W-1:0] : '0;
            if (found && fit_policy == POL_NEXT) begin
              scan_start <= pick_idx;
            end
          end else begin
            res_granted <= load_ok;
            res_chosen  <= load_ok ? idx : '0;
          end
          if (total_wide > 64'(SUM_MAX)) begin
            res_total <= SUM_MAX;
          end else begin
            res_total <= total_wide[TOTAL_W-1:0];
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_granted;
            m_tdata  <= {res_total, res_chosen};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/fpba_ram.sv]
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/fpba_scan.sv]
module fpba_scan
  import fpba_pkg::*;
#(
  parameter int SIZE_BITS = 16,
  parameter int IDXW      = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  scan_ctrl_t                ctrl,
  input  logic                      data_vld,
  input  logic [IDXW-1:0]           data_idx,
  input  logic [SIZE_BITS-1:0]      data,
  input  logic [SIZE_BITS-1:0]      amt,
  output logic                      found,
  output logic [IDXW-1:0]           pick_idx,
  output logic [SIZE_BITS-1:0]      pick_val,
  output logic [SIZE_BITS+IDXW-1:0] sum
);

  logic fits;
  logic take;

  // Compare one entry against the request and the current pick
  always_comb begin
    fits = (data >= amt);
    take = 1'b0;
    if (ctrl.alloc && fits) begin
      if (!found) begin
        take = 1'b1;
      end else begin
        case (ctrl.policy)
          POL_BEST:  take = (data < pick_val);
          POL_WORST: take = (data > pick_val);
          default:   take = 1'b0;
        endcase
      end
    end
  end

  // Accumulate the free total and hold the pick
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.clear) begin
      found <= 1'b0;
    end else if (data_vld && take) begin
      found <= 1'b1;
    end

    if (ctrl.clear) begin
      sum <= '0;
    end else if (data_vld) begin
      sum <= sum + (SIZE_BITS+IDXW)'(data);
      if (take) begin
        pick_idx <= data_idx;
        pick_val <= data;
      end
    end
  end

endmodule

[rtl/fpba_checker.sv]
module fpba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Not ready straight after an item is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // A refused request reports block zero
  a_refused_block_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[3:0] == 4'd0)
    else $error("refused result names a block");

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind fit_policy_block_allocator_core fpba_checker u_fpba_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
